>>> hdl/toeplitz_hankel_matrix_element_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the nested Toeplitz-plus-Hankel element unit
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TOEPLITZ_HANKEL_MATRIX_ELEMENT_MACROS_SVH
`define TOEPLITZ_HANKEL_MATRIX_ELEMENT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked out of reset
`define THME_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("thme assertion failed");

// next-cycle implication, checked out of reset
`define THME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("thme assertion failed");

`else

`define THME_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define THME_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/thme_pkg.sv
// ----------------------------------------------------------------------------
// thme_pkg
// Types and fixed constants of the nested Toeplitz-plus-Hankel element unit.
// ----------------------------------------------------------------------------
`default_nettype none

package thme_pkg;

    // request kinds carried on s_axis_tuser
    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    // configuration register indexes
    localparam logic [1:0] CFG_EXTENT_OUTER  = 2'd0;
    localparam logic [1:0] CFG_EXTENT_MIDDLE = 2'd1;
    localparam logic [1:0] CFG_EXTENT_INNER  = 2'd2;

    localparam int CFG_ADDR_W   = 2;
    localparam int EXTENT_W     = 5;
    localparam int COORD_W      = 4;
    localparam int LOAD_W       = 32;
    localparam int S_TDATA_W    = 56;
    localparam int TERM_CNT_W   = 3;
    localparam logic [TERM_CNT_W-1:0] TERM_LAST = 3'd7;

    // decoded query: block indices at the outer two levels, inner offsets
    typedef struct packed {
        logic                 err;
        logic                 en_sum;
        logic                 en_diff;
        logic [COORD_W-1:0]   outer_diff;
        logic [EXTENT_W-1:0]  outer_sum;
        logic [COORD_W-1:0]   middle_diff;
        logic [EXTENT_W-1:0]  middle_sum;
        logic [EXTENT_W-1:0]  inner_sum;
        logic [COORD_W-1:0]   inner_diff;
    } query_desc_t;

endpackage

`default_nettype wire

>>> hdl/thme_ram.sv
// ----------------------------------------------------------------------------
// thme_ram
// Single-port synchronous RAM with registered read, held when not read.
// ----------------------------------------------------------------------------
`default_nettype none

module thme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hdl/toeplitz_hankel_matrix_element.sv
// ----------------------------------------------------------------------------
// toeplitz_hankel_matrix_element
// Coefficient table with on-demand elements of a nested Toeplitz-plus-Hankel
// matrix, eight table reads summed per element.
// ----------------------------------------------------------------------------
//  channel   | direction | tdata (low bit up)                       | tuser
//  s_axis    | in        | row_outer row_middle row_inner col_outer | op
//            |           | col_middle col_inner load_value          |
//  m_axis    | out       | element_value                            | range_error
//  cfg       | in        | cfg_wr_en, cfg_addr, cfg_wdata (no read) | -
//
//  a query makes 8 reads of the single-port coefficient ram, one per term;
//  a load makes one ram write. the next request is taken while the
//  last read of a query goes out; its data is registered in the ram, added in
//  the read stage and then registered in the output register. a full output
//  register not taken holds the last term of a query and every ram access of the next request.
//  reset is synchronous, active low; the table is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "toeplitz_hankel_matrix_element_macros.svh"

module toeplitz_hankel_matrix_element #(
    parameter int MAX_EXTENT  = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,

    input  wire logic                                   cfg_wr_en,
    input  wire logic [thme_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire logic [thme_pkg::EXTENT_W-1:0]          cfg_wdata,

    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // row_outer, row_middle, row_inner, col_outer, col_middle, col_inner,
    // load_value
    input  wire logic [thme_pkg::S_TDATA_W-1:0]         s_axis_tdata,
    // op
    input  wire logic                                   s_axis_tuser,

    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // element_value, zero padded to whole bytes
    output logic [(((VALUE_WIDTH+3)+7)/8)*8-1:0]        m_axis_tdata,
    // range_error
    output logic                                        m_axis_tuser
);

    import thme_pkg::*;

    localparam int OUT_W       = VALUE_WIDTH + 3;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int LW          = $clog2(MAX_EXTENT);
    localparam int AW          = 3 * LW;
    localparam int DEPTH       = 1 << AW;

    // effective extent of a register value, capped at the table size
    function automatic logic [EXTENT_W-1:0] cap_extent(input logic [EXTENT_W-1:0] v);
        logic [EXTENT_W-1:0] r;
        r = v;
        if (int'(v) > MAX_EXTENT) begin
            r = EXTENT_W'(MAX_EXTENT);
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- config
    logic [EXTENT_W-1:0] ext_outer_reg,  ext_outer_next;
    logic [EXTENT_W-1:0] ext_middle_reg, ext_middle_next;
    logic [EXTENT_W-1:0] ext_inner_reg,  ext_inner_next;

    always_comb begin
        ext_outer_next  = ext_outer_reg;
        ext_middle_next = ext_middle_reg;
        ext_inner_next  = ext_inner_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_EXTENT_OUTER:  ext_outer_next  = cap_extent(cfg_wdata);
                CFG_EXTENT_MIDDLE: ext_middle_next = cap_extent(cfg_wdata);
                CFG_EXTENT_INNER:  ext_inner_next  = cap_extent(cfg_wdata);
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- decode
    logic [COORD_W-1:0]      in_ro, in_rm, in_ri, in_co, in_cm, in_ci;
    logic signed [LOAD_W-1:0] in_load;
    op_t                     in_op;
    query_desc_t             in_desc;
    logic                    in_ld_ok;
    logic [AW-1:0]           in_ld_addr;
    logic [EXTENT_W-1:0]     s_outer, s_middle;

    assign in_ro   = s_axis_tdata[3:0];
    assign in_rm   = s_axis_tdata[7:4];
    assign in_ri   = s_axis_tdata[11:8];
    assign in_co   = s_axis_tdata[15:12];
    assign in_cm   = s_axis_tdata[19:16];
    assign in_ci   = s_axis_tdata[23:20];
    assign in_load = s_axis_tdata[55:24];
    assign in_op   = op_t'(s_axis_tuser);

    assign s_outer  = {1'b0, in_ro} + {1'b0, in_co};
    assign s_middle = {1'b0, in_rm} + {1'b0, in_cm};

    always_comb begin
        in_desc.err = ({1'b0, in_ro} >= ext_outer_reg)  || ({1'b0, in_co} >= ext_outer_reg)
                   || ({1'b0, in_rm} >= ext_middle_reg) || ({1'b0, in_cm} >= ext_middle_reg)
                   || ({1'b0, in_ri} >= ext_inner_reg)  || ({1'b0, in_ci} >= ext_inner_reg);
        in_desc.outer_diff  = (in_ro >= in_co) ? in_ro - in_co : in_co - in_ro;
        in_desc.outer_sum   = (s_outer >= ext_outer_reg) ? s_outer - ext_outer_reg : s_outer;
        in_desc.middle_diff = (in_rm >= in_cm) ? in_rm - in_cm : in_cm - in_rm;
        in_desc.middle_sum  = (s_middle >= ext_middle_reg) ? s_middle - ext_middle_reg
                                                           : s_middle;
        in_desc.inner_sum   = {1'b0, in_ri} + {1'b0, in_ci};
        in_desc.inner_diff  = in_ci - in_ri;
        in_desc.en_sum      = in_desc.inner_sum < ext_inner_reg;
        in_desc.en_diff     = in_ci >= in_ri;
    end

    assign in_ld_ok = (int'(in_ro) < MAX_EXTENT) && (int'(in_rm) < MAX_EXTENT)
                   && (int'(in_ri) < MAX_EXTENT);
    assign in_ld_addr = {LW'(in_ro), LW'(in_rm), LW'(in_ri)};

    // ----------------------------------------------------------- issue stage
    logic                     busy_reg, busy_next;
    op_t                      op_reg, op_next;
    logic [TERM_CNT_W-1:0]    cnt_reg, cnt_next;
    query_desc_t              desc_reg, desc_next;
    logic                     ld_ok_reg, ld_ok_next;
    logic [AW-1:0]            ld_addr_reg, ld_addr_next;
    logic [VALUE_WIDTH-1:0]   ld_value_reg, ld_value_next;

    logic stall, accept, finish, issue_query, issue_load;
    logic term_en;
    logic [EXTENT_W-1:0] sel_outer, sel_middle, sel_inner;
    logic [AW-1:0]       rd_addr;

    logic                   ram_en, ram_we;
    logic [AW-1:0]          ram_addr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    // read stage and output register
    logic             rd_valid_reg, rd_valid_next;
    logic             rd_en_reg, rd_en_next;
    logic             rd_first_reg, rd_first_next;
    logic             rd_last_reg, rd_last_next;
    logic             rd_err_reg, rd_err_next;
    logic [OUT_W-1:0] acc_reg, acc_next;
    logic [OUT_W-1:0] acc_sum;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic             m_err_reg, m_err_next;
    logic             push;

    // last term of a query waits while its result has nowhere to go
    assign stall  = rd_valid_reg && rd_last_reg && m_valid_reg && !m_axis_tready;

    assign issue_query = busy_reg && (op_reg == OP_QUERY) && !stall;
    assign issue_load  = busy_reg && (op_reg == OP_LOAD) && !stall && ld_ok_reg;
    assign finish      = busy_reg && !stall && ((op_reg == OP_LOAD) || (cnt_reg == TERM_LAST));

    assign s_axis_tready = !busy_reg || finish;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // term order: bit 2 outer index, bit 1 middle index, bit 0 inner offset
    assign sel_outer  = cnt_reg[2] ? desc_reg.outer_sum  : {1'b0, desc_reg.outer_diff};
    assign sel_middle = cnt_reg[1] ? desc_reg.middle_sum : {1'b0, desc_reg.middle_diff};
    assign sel_inner  = cnt_reg[0] ? {1'b0, desc_reg.inner_diff} : desc_reg.inner_sum;
    assign term_en    = !desc_reg.err && (cnt_reg[0] ? desc_reg.en_diff : desc_reg.en_sum);
    assign rd_addr    = {LW'(sel_outer), LW'(sel_middle), LW'(sel_inner)};

    assign ram_en   = issue_query || issue_load;
    assign ram_we   = issue_load;
    assign ram_addr = issue_load ? ld_addr_reg : rd_addr;

    always_comb begin
        busy_next     = busy_reg;
        op_next       = op_reg;
        cnt_next      = cnt_reg;
        desc_next     = desc_reg;
        ld_ok_next    = ld_ok_reg;
        ld_addr_next  = ld_addr_reg;
        ld_value_next = ld_value_reg;
        if (finish) begin
            busy_next = 1'b0;
        end
        if (issue_query) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (accept) begin
            busy_next     = 1'b1;
            op_next       = in_op;
            cnt_next      = '0;
            desc_next     = in_desc;
            ld_ok_next    = in_ld_ok;
            ld_addr_next  = in_ld_addr;
            ld_value_next = VALUE_WIDTH'(in_load);
        end
    end

    thme_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_table (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ld_value_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------- accumulate
    assign acc_sum = (rd_first_reg ? '0 : acc_reg)
                   + (rd_en_reg ? OUT_W'(signed'(ram_rdata)) : '0);
    assign push    = rd_valid_reg && rd_last_reg && !stall;

    always_comb begin
        rd_valid_next = rd_valid_reg;
        rd_en_next    = rd_en_reg;
        rd_first_next = rd_first_reg;
        rd_last_next  = rd_last_reg;
        rd_err_next   = rd_err_reg;
        acc_next      = acc_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_err_next    = m_err_reg;
        if (!stall) begin
            rd_valid_next = issue_query;
            rd_en_next    = term_en;
            rd_first_next = cnt_reg == '0;
            rd_last_next  = cnt_reg == TERM_LAST;
            rd_err_next   = desc_reg.err;
            if (rd_valid_reg) begin
                acc_next = acc_sum;
            end
        end
        if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
        if (push) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_err_reg ? '0 : acc_sum;
            m_err_next   = rd_err_reg;
        end
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ext_outer_reg  <= cap_extent(EXTENT_W'(16));
            ext_middle_reg <= cap_extent(EXTENT_W'(16));
            ext_inner_reg  <= cap_extent(EXTENT_W'(16));
            busy_reg       <= 1'b0;
            op_reg         <= OP_LOAD;
            cnt_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            ext_outer_reg  <= ext_outer_next;
            ext_middle_reg <= ext_middle_next;
            ext_inner_reg  <= ext_inner_next;
            busy_reg       <= busy_next;
            op_reg         <= op_next;
            cnt_reg        <= cnt_next;
            rd_valid_reg   <= rd_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        desc_reg     <= desc_next;
        ld_ok_reg    <= ld_ok_next;
        ld_addr_reg  <= ld_addr_next;
        ld_value_reg <= ld_value_next;
        rd_en_reg    <= rd_en_next;
        rd_first_reg <= rd_first_next;
        rd_last_reg  <= rd_last_next;
        rd_err_reg   <= rd_err_next;
        acc_reg      <= acc_next;
        m_data_reg   <= m_data_next;
        m_err_reg    <= m_err_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(m_data_reg);
    assign m_axis_tuser  = m_err_reg;

    // ---------------------------------------------------------- assertions
    `THME_ASSERT_IMPLIES(a_stall_no_ram, aclk, aresetn, stall, !ram_en)
    `THME_ASSERT_NEXT(a_push_shows, aclk, aresetn, push, m_axis_tvalid)
    `THME_ASSERT_IMPLIES(a_err_zero, aclk, aresetn, m_valid_reg && m_err_reg, m_data_reg == '0)
    `THME_ASSERT_IMPLIES(a_cnt_in_query, aclk, aresetn, cnt_reg != '0, busy_reg && op_reg == OP_QUERY)

endmodule

`default_nettype wire
